### rtl/sae_pkg.sv
// Shared types and constants for the shifting array engine.
package sae_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_APPEND    = 3'd1,
    OP_INSERT    = 3'd2,
    OP_DEL_VALUE = 3'd3,
    OP_DEL_INDEX = 3'd4,
    OP_SEARCH    = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // What the row of cells does this cycle.
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2,
    SH_ROTATE = 2'd3
  } shift_mode_t;

  typedef struct packed {
    shift_mode_t        mode;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } shift_ctl_t;

endpackage

### rtl/sae_cell.sv
// One storage cell of the element row; takes data from a neighbor or the insert value, or holds.
module sae_cell import sae_pkg::*; (
  input  logic              clk,
  input  shift_ctl_t        ctl,
  input  logic [IDX_W-1:0]  slot,
  input  logic [DATA_W-1:0] lower,
  input  logic [DATA_W-1:0] upper,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.mode)
      SH_INSERT: begin
        if (slot > ctl.pos) begin
          data_next = lower;
        end else if (slot == ctl.pos) begin
          data_next = ctl.value;
        end
      end
      SH_DELETE: begin
        if (slot >= ctl.pos) begin
          data_next = upper;
        end
      end
      SH_ROTATE: data_next = upper;
      default:   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/shifting_array_engine_top.sv
// Top level of the shifting array engine: sequencer, fill count and cell row.
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------
//  command   start / busy       operation, value, index
//  result    done (strobe)      status, position, element, count, last
//
// Clear, append, insert, delete by index and unused codes: the result strobe
//   follows on the next cycle and a new command may be taken then.
// Search, delete by value and dump: the cell row rotates once around so every
//   element passes cell 0, where the single comparator and the dump output tap
//   sit; the finishing state (S_FIN) then completes the op.
// A dump gives one transaction per stored element during the rotation; an empty dump gives one closing result.
// Reset (rst, synchronous) empties the array; element storage is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module shifting_array_engine_top import sae_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               operation,
  input  logic signed [DATA_W-1:0] value,
  input  logic [4:0]               index,
  output logic                     done,
  output logic [1:0]               status,
  output logic [4:0]               position,
  output logic signed [DATA_W-1:0] element,
  output logic [5:0]               count,
  output logic                     last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              hit, hit_next;
  logic [IDX_W-1:0]  hit_pos, hit_pos_next;
  op_t               scan_op, scan_op_next;
  logic [DATA_W-1:0] scan_val, scan_val_next;

  logic              done_next;
  status_t           status_r, status_next;
  logic [IDX_W-1:0]  position_r, position_next;
  logic [DATA_W-1:0] element_r, element_next;
  logic              last_next;

  shift_ctl_t        ctl;
  logic [DATA_W-1:0] cell_data [DEPTH];

  logic              accept;
  logic              in_range;   // scan position is below the fill count
  logic              full;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = ({1'b0, scan_idx} < fill_count);
  assign full     = (fill_count == CNT_W'(DEPTH));

  // Cell row: ring of neighbors so each rotation step brings the next element to
  // cell 0 and a full turn around the ring restores the order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sae_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .slot  (IDX_W'(i)),
      .lower (cell_data[(i + DEPTH - 1) % DEPTH]),
      .upper (cell_data[(i + 1) % DEPTH]),
      .data  (cell_data[i])
    );
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    scan_idx_next   = scan_idx;
    hit_next        = hit;
    hit_pos_next    = hit_pos;
    scan_op_next    = scan_op;
    scan_val_next   = scan_val;

    done_next     = 1'b0;
    status_next   = ST_OK;
    position_next = '0;
    element_next  = '0;
    last_next     = 1'b1;

    ctl.mode  = SH_HOLD;
    ctl.pos   = '0;
    ctl.value = value;

    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (operation)
            OP_CLEAR: fill_count_next = '0;
            OP_APPEND, OP_INSERT: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                ctl.mode = SH_INSERT;
                // insert at or past the end appends
                if (operation == OP_APPEND || {1'b0, index} >= fill_count) begin
                  ctl.pos = fill_count[IDX_W-1:0];
                end else begin
                  ctl.pos = index;
                end
                fill_count_next = fill_count + CNT_W'(1);
              end
            end
            OP_DEL_INDEX: begin
              if ({1'b0, index} >= fill_count) begin
                status_next = ST_BAD_INDEX;
              end else begin
                ctl.mode        = SH_DELETE;
                ctl.pos         = index;
                fill_count_next = fill_count - CNT_W'(1);
              end
            end
            OP_DEL_VALUE, OP_SEARCH, OP_DUMP: begin
              done_next     = 1'b0;
              state_next    = S_SCAN;
              scan_idx_next = '0;
              hit_next      = 1'b0;
              hit_pos_next  = '0;
              scan_op_next  = op_t'(operation);
              scan_val_next = value;
            end
            default: ;  // unused code: plain ok result
          endcase
        end
      end

      S_SCAN: begin
        ctl.mode = SH_ROTATE;
        // cell 0 holds element scan_idx; later matches override earlier ones
        if (in_range && cell_data[0] == scan_val) begin
          hit_next     = 1'b1;
          hit_pos_next = scan_idx;
        end
        if (scan_op == OP_DUMP && in_range) begin
          done_next     = 1'b1;
          position_next = scan_idx;
          element_next  = cell_data[0];
          last_next     = (CNT_W'(scan_idx) + CNT_W'(1) == fill_count);
        end
        scan_idx_next = scan_idx + IDX_W'(1);
        if (scan_idx == IDX_W'(DEPTH - 1)) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        state_next = S_IDLE;
        case (scan_op)
          OP_SEARCH: begin
            done_next = 1'b1;
            if (hit) begin
              position_next = hit_pos;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          OP_DEL_VALUE: begin
            done_next = 1'b1;
            if (hit) begin
              ctl.mode        = SH_DELETE;
              ctl.pos         = hit_pos;
              fill_count_next = fill_count - CNT_W'(1);
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          OP_DUMP: begin
            // empty dump still owes one closing result
            done_next = (fill_count == '0);
          end
          default: ;
        endcase
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
      scan_idx   <= '0;
      hit        <= 1'b0;
      hit_pos    <= '0;
      scan_op    <= OP_CLEAR;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      done       <= done_next;
      scan_idx   <= scan_idx_next;
      hit        <= hit_next;
      hit_pos    <= hit_pos_next;
      scan_op    <= scan_op_next;
    end
  end

  // result payload and scan key: no reset needed
  always_ff @(posedge clk) begin
    scan_val   <= scan_val_next;
    status_r   <= status_next;
    position_r <= position_next;
    element_r  <= element_next;
    count      <= 6'(fill_count_next);
    last       <= last_next;
  end

  assign status   = status_r;
  assign position = 5'(position_r);
  assign element  = element_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_multi_only_dump: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> (scan_op == OP_DUMP && state != S_IDLE))
    else $error("non-final result outside a dump");

  a_scan_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_SEARCH || operation == OP_DEL_VALUE ||
                operation == OP_DUMP)) |=> (busy && !done))
    else $error("scan transaction did not enter scan");

  a_rotate_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (scan_idx == '0 && $past(state) == S_SCAN))
    else $error("finish without full rotation");
`endif

endmodule

### test/sae_checker.sv
`timescale 1ns / 100ps
// Checker for the shifting array engine: tracks the array and checks every result.
module sae_checker import sae_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [2:0]               operation,
  input  logic signed [DATA_W-1:0] value,
  input  logic [4:0]               index,
  input  logic                     done,
  input  logic [1:0]               status,
  input  logic [4:0]               position,
  input  logic signed [DATA_W-1:0] element,
  input  logic [5:0]               count,
  input  logic                     last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    status_t                  status;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] element;
    logic [5:0]               count;
    logic                     last;
  } array_result_t;

  // shadow copy of the cell row and fill count
  logic signed [DATA_W-1:0] cells [DEPTH];
  int                       fill = 0;
  array_result_t            result_q[$];
  int                       errs = 0;

  function automatic int find_last(input logic signed [DATA_W-1:0] val);
    int where;
    where = -1;
    for (int i = 0; i < fill; i++) begin
      if (cells[i] == val) where = i;
    end
    return where;
  endfunction

  task automatic remove_at(input int p);
    for (int i = p; i + 1 < fill; i++) cells[i] = cells[i + 1];
    fill--;
  endtask

  task automatic push_result(input status_t st, input logic [IDX_W-1:0] pos,
                             input logic signed [DATA_W-1:0] elem, input logic lst);
    array_result_t r;
    r.status   = st;
    r.position = pos;
    r.element  = elem;
    r.count    = fill[5:0];
    r.last     = lst;
    result_q.push_back(r);
  endtask

  // Apply one accepted command to the shadow array and queue its results.
  task automatic predict_cmd(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                             input logic [4:0] idx);
    int p;
    case (op)
      OP_CLEAR: begin
        fill = 0;
        push_result(ST_OK, '0, '0, 1'b1);
      end
      OP_APPEND, OP_INSERT: begin
        if (fill >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          // insert at or past the end appends
          p = (op == OP_APPEND || idx >= fill) ? fill : int'(idx);
          for (int i = fill; i > p; i--) cells[i] = cells[i - 1];
          cells[p] = val;
          fill++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DEL_VALUE, OP_SEARCH: begin
        p = find_last(val);
        if (p < 0) begin
          push_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end else if (op == OP_SEARCH) begin
          push_result(ST_OK, IDX_W'(p), '0, 1'b1);
        end else begin
          remove_at(p);
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DEL_INDEX: begin
        if (idx >= fill) begin
          push_result(ST_BAD_INDEX, '0, '0, 1'b1);
        end else begin
          remove_at(int'(idx));
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          push_result(ST_OK, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++)
            push_result(ST_OK, IDX_W'(i), cells[i], (i + 1 == fill));
        end
      end
      default: begin
        push_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errs++;
      $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
               $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    array_result_t want;
    if (rst) begin
      result_q.delete();
      fill = 0;
    end else begin
      // results first: a command's results never come on the edge that takes it
      if (done) begin
        if (result_q.size() == 0) begin
          errs++;
          $display("%0t ns: result with no transaction waiting, status %0d count %0d",
                   $time, status, count);
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("position", 32'(want.position), 32'(position));
          check_field("element", want.element, element);
          check_field("count", 32'(want.count), 32'(count));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (start && !busy) predict_cmd(operation, value, index);
    end
    pending    <= result_q.size();
    fail_count <= errs;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the shifting array engine: command stimulus, watchdog and verdict.
module tb_top;
  import sae_pkg::*;

  // code 7 has no package name; the block takes it as a no-op
  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam int         WATCHDOG_LIMIT = 1000;
  // give the tail a margin on top of the longest op, a full rotation scan
  localparam int         TAIL_CYCLES    = 48;
  localparam int         GROW_LEN       = 60;
  localparam int         SEG_LEN        = 90;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic                     busy;
  logic [2:0]               operation = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic [4:0]               index     = '0;
  logic                     done;
  logic [1:0]               status;
  logic [4:0]               position;
  logic signed [DATA_W-1:0] element;
  logic [5:0]               count;
  logic                     last;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_cycles = 0;

  // small set of values reused so that duplicates, hits and last-match cases occur
  logic signed [DATA_W-1:0] value_pool [6];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  shifting_array_engine_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .index     (index),
    .done      (done),
    .status    (status),
    .position  (position),
    .element   (element),
    .count     (count),
    .last      (last)
  );

  sae_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .index      (index),
    .done       (done),
    .status     (status),
    .position   (position),
    .element    (element),
    .count      (count),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: any accepted command or result restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transaction for %0d cycles", $time, stall_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One command transaction. Random idle cycles go in front; start then stays up
  // until the edge that takes it (start high, busy low). start is left high on
  // return so a back-to-back command never sees a low/high pair in one step.
  task automatic send_cmd(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                          input logic [4:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    index     <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every queued result is back, then let the block settle.
  // pending is updated by the checker one edge late, so look after an edge.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(3))
        0:       value_pool[k] = 32'sh7fff_ffff;
        1:       value_pool[k] = 32'sh8000_0000;
        2:       value_pool[k] = $signed($urandom_range(15)) - 8;
        default: value_pool[k] = $urandom;
      endcase
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 55) return value_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  // Grow segments push toward a full array; shrink segments drain it again.
  function automatic logic [2:0] pick_op(input bit grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 1)  return OP_CLEAR;
      if (r < 50) return OP_APPEND;
      if (r < 80) return OP_INSERT;
      if (r < 84) return OP_DEL_VALUE;
      if (r < 88) return OP_DEL_INDEX;
      if (r < 93) return OP_SEARCH;
      if (r < 98) return OP_DUMP;
    end else begin
      if (r < 2)  return OP_CLEAR;
      if (r < 10) return OP_APPEND;
      if (r < 16) return OP_INSERT;
      if (r < 42) return OP_DEL_VALUE;
      if (r < 70) return OP_DEL_INDEX;
      if (r < 86) return OP_SEARCH;
      if (r < 97) return OP_DUMP;
    end
    return OP_UNUSED;
  endfunction

  task automatic run_random(input int n_items);
    logic [4:0] idx;
    refresh_pool();
    for (int k = 0; k < n_items; k++) begin
      if (k % SEG_LEN == 0 && k != 0) refresh_pool();
      // half full range, half low indexes that land inside a small array
      idx = ($urandom_range(1) != 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
      send_cmd(pick_op((k % SEG_LEN) < GROW_LEN), pick_value(), idx);
    end
  endtask

  // Directed opening: empty-array cases, extreme values, front / middle /
  // past-end inserts, last-match search and delete, in-range and out-of-range
  // delete by index, dumps, clear and the unused code.
  task automatic run_directed();
    send_cmd(OP_DUMP,      '0,             5'd0);   // empty dump
    send_cmd(OP_SEARCH,    32'sd5,         5'd0);   // missing value, empty
    send_cmd(OP_DEL_VALUE, 32'sd5,         5'd0);   // missing value, empty
    send_cmd(OP_DEL_INDEX, '0,             5'd0);   // bad index, empty
    send_cmd(OP_UNUSED,    32'sh7fff_ffff, 5'd31);
    send_cmd(OP_APPEND,    32'sh7fff_ffff, 5'd0);
    send_cmd(OP_APPEND,    32'sh8000_0000, 5'd0);
    send_cmd(OP_APPEND,    -32'sd1,        5'd0);
    send_cmd(OP_INSERT,    32'sd0,         5'd0);   // front
    send_cmd(OP_INSERT,    32'sd7,         5'd31);  // past end appends
    send_cmd(OP_INSERT,    32'sd7,         5'd2);   // middle, duplicate value
    send_cmd(OP_APPEND,    32'sd0,         5'd0);
    send_cmd(OP_SEARCH,    32'sd7,         5'd0);   // last of two matches
    send_cmd(OP_SEARCH,    32'sd123,       5'd0);   // missing value
    send_cmd(OP_DUMP,      '0,             5'd0);
    send_cmd(OP_DEL_VALUE, 32'sd7,         5'd0);   // removes the later 7
    send_cmd(OP_DEL_INDEX, '0,             5'd0);
    send_cmd(OP_DEL_INDEX, '0,             5'd4);   // last element
    send_cmd(OP_DEL_INDEX, '0,             5'd4);   // index equal to count
    send_cmd(OP_DEL_INDEX, '0,             5'd31);  // far out of range
    send_cmd(OP_DUMP,      '0,             5'd0);
    send_cmd(OP_CLEAR,     '0,             5'd0);
    send_cmd(OP_DUMP,      '0,             5'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: light sender idling
    idle_pct = 27;
    run_directed();
    run_random(150);
    drain();   // sender waits here for every result

    // phase 2: heavy sender idling
    idle_pct = 71;
    run_random(150);
    drain();

    // phase 3: back to back
    idle_pct = 0;
    run_random(160);
    drain();

    if (pending != 0) $display("%0t ns: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sae_pkg.sv
rtl/sae_cell.sv
rtl/shifting_array_engine_top.sv
test/sae_checker.sv
test/tb_top.sv
